// File: rtl/seck_pkg.sv
// seck_pkg: shared types and constants for the squared-exponential kernel block.
// Used by seck_cfg, seck_mul, se_kernel_changepoint_scale and seck_chk.
// No dependencies.
package seck_pkg;

  // Q16.16 data and shared multiplier widths
  localparam int unsigned DataW = 32;
  localparam int unsigned MulW  = 33;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned DistW = 64;
  localparam int unsigned RW    = 29;
  localparam int unsigned CfgIdxW = 3;

  // 1.0 in Q1.32
  localparam logic [MulW-1:0] OneQ32 = {1'b1, {DataW{1'b0}}};

  // reciprocal constants: floor(n*K >> 34) = n/5, floor(n*K >> 33) = n/3 for 32-bit n
  localparam logic [MulW-1:0] RecipDiv5 = 33'h0_CCCC_CCCD;
  localparam logic [MulW-1:0] RecipDiv3 = 33'h0_AAAA_AAAB;

  // register reset value (1.0 in Q16.16)
  localparam logic [DataW-1:0] OneQ16 = 32'h0001_0000;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE   = 3'd0,
    REG_ILS    = 3'd1,
    REG_SCALE0 = 3'd2,
    REG_SCALE1 = 3'd3,
    REG_SCALEX = 3'd4
  } reg_idx_t;

  // kernel modes
  localparam logic MODE_COV   = 1'b0;
  localparam logic MODE_DERIV = 1'b1;

  // configuration bundle from the register file to the datapath
  typedef struct packed {
    logic             mode;
    logic [DataW-1:0] inv_ls;
    logic [DataW-1:0] scale0;
    logic [DataW-1:0] scale1;
    logic [DataW-1:0] scalex;
  } cfg_t;

endpackage

// File: rtl/seck_mul.sv
// seck_mul: shared 33x33 unsigned multiplier with a registered product.
// Depends on seck_pkg for widths.
module seck_mul import seck_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [MulW-1:0]  op_a,
  input  logic [MulW-1:0]  op_b,
  output logic [ProdW-1:0] prod_r
);

  logic [ProdW-1:0] prod_nxt;

  // product loads only on cycles that issue a multiply; held otherwise
  always_comb begin
    prod_nxt = prod_r;
    if (en) begin
      prod_nxt = {{MulW{1'b0}}, op_a} * {{MulW{1'b0}}, op_b};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// File: rtl/seck_cfg.sv
// seck_cfg: configuration register file (mode, inverse length scale, output scales).
// Depends on seck_pkg for cfg_t and register indexes.
module seck_cfg import seck_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data,
  output cfg_t               cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   cfg_nxt.mode   = cfg_data[0];
        REG_ILS:    cfg_nxt.inv_ls = cfg_data;
        REG_SCALE0: cfg_nxt.scale0 = cfg_data;
        REG_SCALE1: cfg_nxt.scale1 = cfg_data;
        REG_SCALEX: cfg_nxt.scalex = cfg_data;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= MODE_COV;
      cfg_r.inv_ls <= OneQ16;
      cfg_r.scale0 <= OneQ16;
      cfg_r.scale1 <= OneQ16;
      cfg_r.scalex <= OneQ16;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/se_kernel_changepoint_scale.sv
// se_kernel_changepoint_scale: squared-exponential kernel entry with changepoint scales.
// Depends on seck_pkg, seck_cfg (register file) and seck_mul (shared multiplier).
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tdata {coord_b, coord_a}, tuser {seg_b, seg_a}, tlast
//  out_    | out | out_tvalid/tready   | tdata kernel_value, tuser saturated
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A coordinate request steps through accept, scale multiply, square and accumulate.
// A last request then runs on the one shared multiplier: range check, polynomial,
// eight squarings, scale pass; zero or cutoff skips straight to the scale pass.
// Synchronous active-low reset clears the distance, sequencer and output valid.
// The result sits in an output register; a stalled result only holds the block
// when the next result is ready to be written.
module se_kernel_changepoint_scale import seck_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [63:0]        in_tdata,   // [31:0] coord_a, [63:32] coord_b
  input  logic [1:0]         in_tuser,   // [0] segment_a, [1] segment_b
  input  logic               in_tlast,   // last
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [DataW-1:0]   out_tdata,  // [31:0] kernel_value
  output logic               out_tuser,  // [0] saturated
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data
);

  typedef enum logic [20:0] {
    ST_IDLE = 21'h000001,
    ST_SCL  = 21'h000002,
    ST_SQR  = 21'h000004,
    ST_ACC  = 21'h000008,
    ST_CHK  = 21'h000010,
    ST_DIV5 = 21'h000020,
    ST_T5   = 21'h000040,
    ST_MUL4 = 21'h000080,
    ST_T4   = 21'h000100,
    ST_MUL3 = 21'h000200,
    ST_DIV3 = 21'h000400,
    ST_T3   = 21'h000800,
    ST_MUL2 = 21'h001000,
    ST_T2   = 21'h002000,
    ST_MUL1 = 21'h004000,
    ST_T1   = 21'h008000,
    ST_SQ   = 21'h010000,
    ST_SQW  = 21'h020000,
    ST_SCV  = 21'h040000,
    ST_DSC  = 21'h080000,
    ST_OUT  = 21'h100000
  } state_t;

  state_t             state_r, state_nxt;
  cfg_t               cfg;
  logic [DataW-1:0]   mag_r, mag_nxt;
  logic               seg_a_r, seg_a_nxt, seg_b_r, seg_b_nxt, last_r, last_nxt;
  logic               flag_r, flag_nxt;
  logic [DistW-1:0]   dist_r, dist_nxt;
  logic [RW-1:0]      r_r, r_nxt;
  logic [MulW-1:0]    work_r, work_nxt;
  logic [2:0]         sq_cnt_r, sq_cnt_nxt;
  logic [DataW-1:0]   out_data_r, out_data_nxt;
  logic               out_sat_r, out_sat_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               mul_en;
  logic [MulW-1:0]    mul_a, mul_b;
  logic [ProdW-1:0]   prod_r;

  logic signed [32:0] diff;
  logic [DistW-1:0]   term;
  logic [DistW:0]     dist_sum;
  logic [DataW-1:0]   scale_sel;
  logic               out_free;

  seck_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  seck_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;
  assign out_free   = !out_valid_r || out_tready;

  // signed coordinate difference, taken straight off the request
  assign diff = {in_tdata[31], in_tdata[31:0]} - {in_tdata[63], in_tdata[63:32]};

  // squared term, saturated when the scaled difference reaches 2^16
  assign term     = flag_r ? {DistW{1'b1}} : {16'd0, prod_r[63:16]};
  assign dist_sum = {1'b0, dist_r} + {1'b0, term};

  // output scale from segment labels
  always_comb begin
    if (!seg_a_r && !seg_b_r) begin
      scale_sel = cfg.scale0;
    end else if (seg_a_r && seg_b_r) begin
      scale_sel = cfg.scale1;
    end else begin
      scale_sel = cfg.scalex;
    end
  end

  // multiplier operand select per sequencer step
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      ST_SCL: begin
        mul_a = {1'b0, mag_r};
        mul_b = {1'b0, cfg.inv_ls};
      end
      ST_SQR: begin
        mul_a = {1'b0, prod_r[47:16]};
        mul_b = {1'b0, prod_r[47:16]};
      end
      ST_DIV5: begin
        mul_a = {4'd0, r_r};
        mul_b = RecipDiv5;
      end
      ST_MUL4, ST_MUL3, ST_MUL2, ST_MUL1: begin
        mul_a = {4'd0, r_r};
        mul_b = work_r;
      end
      ST_DIV3: begin
        mul_a = {1'b0, prod_r[63:32]};
        mul_b = RecipDiv3;
      end
      ST_SQ: begin
        mul_a = {1'b0, work_r[31:0]};
        mul_b = {1'b0, work_r[31:0]};
      end
      ST_SCV: begin
        mul_a = (cfg.mode == MODE_COV) ? {1'b0, scale_sel} : {11'd0, dist_r[21:0]};
        mul_b = work_r;
      end
      ST_DSC: begin
        mul_a = {1'b0, scale_sel};
        mul_b = {11'd0, prod_r[53:32]};
      end
      default: mul_en = 1'b0;
    endcase
  end

  // sequencer and datapath registers
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    seg_a_nxt     = seg_a_r;
    seg_b_nxt     = seg_b_r;
    last_nxt      = last_r;
    flag_nxt      = flag_r;
    dist_nxt      = dist_r;
    r_nxt         = r_r;
    work_nxt      = work_r;
    sq_cnt_nxt    = sq_cnt_r;
    out_data_nxt  = out_data_r;
    out_sat_nxt   = out_sat_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mag_nxt   = diff[32] ? 32'(-diff) : diff[31:0];
          seg_a_nxt = in_tuser[0];
          seg_b_nxt = in_tuser[1];
          last_nxt  = in_tlast;
          state_nxt = ST_SCL;
        end
      end
      ST_SCL: state_nxt = ST_SQR;
      ST_SQR: begin
        flag_nxt  = |prod_r[63:48];
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        dist_nxt  = dist_sum[DistW] ? {DistW{1'b1}} : dist_sum[DistW-1:0];
        state_nxt = last_r ? ST_CHK : ST_IDLE;
      end
      // range check on x = d/2: cutoff at 32.0, exact 1.0 at zero
      ST_CHK: begin
        r_nxt      = {dist_r[21:1], 8'd0};
        sq_cnt_nxt = '0;
        if (|dist_r[DistW-1:22]) begin
          work_nxt  = '0;
          state_nxt = ST_SCV;
        end else if (!(|dist_r[21:1])) begin
          work_nxt  = OneQ32;
          state_nxt = ST_SCV;
        end else begin
          state_nxt = ST_DIV5;
        end
      end
      ST_DIV5: state_nxt = ST_T5;
      ST_T5: begin
        work_nxt  = OneQ32 - {3'd0, prod_r[63:34]};
        state_nxt = ST_MUL4;
      end
      ST_MUL4: state_nxt = ST_T4;
      ST_T4: begin
        work_nxt  = OneQ32 - {3'd0, prod_r[63:34]};
        state_nxt = ST_MUL3;
      end
      ST_MUL3: state_nxt = ST_DIV3;
      ST_DIV3: state_nxt = ST_T3;
      ST_T3: begin
        work_nxt  = OneQ32 - {2'd0, prod_r[63:33]};
        state_nxt = ST_MUL2;
      end
      ST_MUL2: state_nxt = ST_T2;
      ST_T2: begin
        work_nxt  = OneQ32 - {2'd0, prod_r[63:33]};
        state_nxt = ST_MUL1;
      end
      ST_MUL1: state_nxt = ST_T1;
      ST_T1: begin
        work_nxt  = OneQ32 - {1'b0, prod_r[63:32]};
        state_nxt = ST_SQ;
      end
      // eight squarings, capped at 1.0
      ST_SQ: begin
        flag_nxt  = work_r[32];
        state_nxt = ST_SQW;
      end
      ST_SQW: begin
        work_nxt   = flag_r ? OneQ32 : {1'b0, prod_r[63:32]};
        sq_cnt_nxt = sq_cnt_r + 3'd1;
        state_nxt  = (sq_cnt_r == 3'd7) ? ST_SCV : ST_SQ;
      end
      ST_SCV: state_nxt = (cfg.mode == MODE_COV) ? ST_OUT : ST_DSC;
      ST_DSC: state_nxt = ST_OUT;
      // write result once the output register is free, then clear distance
      ST_OUT: begin
        if (out_free) begin
          if (cfg.mode == MODE_COV) begin
            out_sat_nxt  = |prod_r[65:64];
            out_data_nxt = (|prod_r[65:64]) ? {DataW{1'b1}} : prod_r[63:32];
          end else begin
            out_sat_nxt  = |prod_r[65:48];
            out_data_nxt = (|prod_r[65:48]) ? {DataW{1'b1}} : prod_r[47:16];
          end
          out_valid_nxt = 1'b1;
          dist_nxt      = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dist_r      <= '0;
      out_valid_r <= 1'b0;
      sq_cnt_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      dist_r      <= dist_nxt;
      out_valid_r <= out_valid_nxt;
      sq_cnt_r    <= sq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    seg_a_r    <= seg_a_nxt;
    seg_b_r    <= seg_b_nxt;
    last_r     <= last_nxt;
    flag_r     <= flag_nxt;
    r_r        <= r_nxt;
    work_r     <= work_nxt;
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
  end

endmodule

// File: rtl/seck_chk.sv
// seck_chk: port-level checks for se_kernel_changepoint_scale, bound to the top level.
// Depends on seck_pkg for widths.
module seck_chk import seck_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             in_tlast,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [DataW-1:0] out_tdata,
  input logic             out_tuser
);

  // block is busy for the cycle after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready high right after an accepted request");

  // a non-last coordinate produces no result while it is processed (checked when none is pending)
  a_no_result_mid_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tlast && !out_tvalid)
      |-> ##1 !out_tvalid ##1 !out_tvalid ##1 !out_tvalid)
    else $error("result appeared for a non-last coordinate");

  // stalled result stays valid
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // stalled result payload is stable
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(out_tdata) && $stable(out_tuser)))
    else $error("out payload changed while stalled");

endmodule

bind se_kernel_changepoint_scale seck_chk u_seck_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
